// ===== hw/rtl/mrl_pkg.sv =====
// Shared types and constants for the message ring with id lookup.
`timescale 1ns / 1ps

package mrl_pkg;

    localparam int RING_DEPTH_DEF = 16;

    localparam int CMD_W  = 2;
    localparam int ID_W   = 31;
    localparam int TYPE_W = 8;
    localparam int LEN_W  = 16;
    localparam int REC_W  = ID_W + TYPE_W + LEN_W;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic clear;
        logic push;
        logic rd_en;
        logic load_out;
    } ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_last;
    } sts_t;

endpackage

// ===== hw/rtl/mrl_req_if.sv =====
// Request channel interface for the message ring.
`timescale 1ns / 1ps

interface mrl_req_if
    import mrl_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [ID_W-1:0]   msg_id;
    logic [TYPE_W-1:0] msg_type;
    logic [LEN_W-1:0]  msg_len;

    modport source (output valid, output cmd, output msg_id, output msg_type,
                    output msg_len, input ready);
    modport sink (input valid, input cmd, input msg_id, input msg_type,
                  input msg_len, output ready);
endinterface

// ===== hw/rtl/mrl_rsp_if.sv =====
// Response channel interface for the message ring.
`timescale 1ns / 1ps

interface mrl_rsp_if
    import mrl_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              found;
    logic [TYPE_W-1:0] found_type;
    logic [LEN_W-1:0]  found_len;

    modport source (output valid, output found, output found_type, output found_len,
                    input ready);
    modport sink (input valid, input found, input found_type, input found_len,
                  output ready);
endinterface

// ===== hw/rtl/message_ring_with_id_lookup.sv =====
// Top level of the message ring with id lookup.
`timescale 1ns / 1ps

// A ring of RING_DEPTH records (id, type, length) kept in one RAM with a valid
// bit per entry, so a clear takes effect at once and unwritten entries read as
// zero. Every request gives exactly one response. A lookup is paced by the
// single RAM read port scanning one record per cycle, followed by one compare
// stage and the response load. Among matching records the one at the highest
// index is reported. The response sits in an output register, so the next
// request is taken while an earlier response still waits.
module message_ring_with_id_lookup
    import mrl_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    mrl_req_if.sink        req,
    mrl_rsp_if.source      rsp
);

    ctl_t ctl;
    sts_t sts;

    mrl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_cmd   (req.cmd),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .ctl       (ctl),
        .sts       (sts)
    );

    mrl_dp #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .sts        (sts),
        .msg_id     (req.msg_id),
        .msg_type   (req.msg_type),
        .msg_len    (req.msg_len),
        .found      (rsp.found),
        .found_type (rsp.found_type),
        .found_len  (rsp.found_len)
    );

endmodule

// ===== hw/rtl/mrl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/mrl_dp.sv =====
// Datapath: record storage, valid bits, write pointer, scan and match logic.
`timescale 1ns / 1ps

module mrl_dp
    import mrl_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ctl_t              ctl,
    output sts_t              sts,
    input  logic [ID_W-1:0]   msg_id,
    input  logic [TYPE_W-1:0] msg_type,
    input  logic [LEN_W-1:0]  msg_len,
    output logic              found,
    output logic [TYPE_W-1:0] found_type,
    output logic [LEN_W-1:0]  found_len
);

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(RING_DEPTH - 1);

    logic [RING_DEPTH-1:0] valid_reg, valid_next;
    logic [PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]      scan_idx_reg, scan_idx_next;
    logic                  cmp_en_reg, cmp_en_next;
    logic                  hit_reg, hit_next;
    logic                  rd_valid_reg;
    logic [ID_W-1:0]       key_reg;
    logic [TYPE_W-1:0]     hit_type_reg, hit_type_next;
    logic [LEN_W-1:0]      hit_len_reg, hit_len_next;
    logic                  found_reg;
    logic [TYPE_W-1:0]     found_type_reg;
    logic [LEN_W-1:0]      found_len_reg;

    logic [REC_W-1:0]  rd_data;
    logic [ID_W-1:0]   entry_id;
    logic [TYPE_W-1:0] entry_type;
    logic [LEN_W-1:0]  entry_len;
    logic              match;

    mrl_ram #(
        .WIDTH (REC_W),
        .DEPTH (RING_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ctl.push),
        .wr_addr (wr_ptr_reg),
        .wr_data ({msg_id, msg_type, msg_len}),
        .rd_en   (ctl.rd_en),
        .rd_addr (scan_idx_reg),
        .rd_data (rd_data)
    );

    // An entry never written since the last clear reads as all zero.
    always_comb
    begin
        entry_id   = rd_valid_reg ? rd_data[REC_W-1 -: ID_W] : '0;
        entry_type = rd_valid_reg ? rd_data[LEN_W +: TYPE_W] : '0;
        entry_len  = rd_valid_reg ? rd_data[LEN_W-1:0] : '0;
        match      = cmp_en_reg && (entry_id == key_reg);
    end

    always_comb
    begin
        valid_next    = valid_reg;
        wr_ptr_next   = wr_ptr_reg;
        scan_idx_next = scan_idx_reg;
        hit_next      = hit_reg;
        hit_type_next = hit_type_reg;
        hit_len_next  = hit_len_reg;
        cmp_en_next   = ctl.rd_en;

        if (ctl.clear)
        begin
            valid_next  = '0;
            wr_ptr_next = '0;
        end
        else if (ctl.push)
        begin
            valid_next[wr_ptr_reg] = 1'b1;
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
        end

        if (ctl.accept)
        begin
            scan_idx_next = '0;
        end
        else if (ctl.rd_en)
        begin
            scan_idx_next = (scan_idx_reg == LAST_IDX) ? '0 : scan_idx_reg + 1'b1;
        end

        // Ascending scan: a later match overrides, so the highest index wins.
        if (ctl.accept)
        begin
            hit_next      = 1'b0;
            hit_type_next = '0;
            hit_len_next  = '0;
        end
        else if (match)
        begin
            hit_next      = 1'b1;
            hit_type_next = entry_type;
            hit_len_next  = entry_len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            wr_ptr_reg   <= '0;
            scan_idx_reg <= '0;
            cmp_en_reg   <= 1'b0;
            hit_reg      <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            wr_ptr_reg   <= wr_ptr_next;
            scan_idx_reg <= scan_idx_next;
            cmp_en_reg   <= cmp_en_next;
            hit_reg      <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_type_reg <= hit_type_next;
        hit_len_reg  <= hit_len_next;
        if (ctl.rd_en)
        begin
            rd_valid_reg <= valid_reg[scan_idx_reg];
        end
        if (ctl.accept)
        begin
            key_reg <= msg_id;
        end
        if (ctl.load_out)
        begin
            found_reg      <= hit_reg;
            found_type_reg <= hit_type_reg;
            found_len_reg  <= hit_len_reg;
        end
    end

    assign sts.scan_last = (scan_idx_reg == LAST_IDX);
    assign found         = found_reg;
    assign found_type    = found_type_reg;
    assign found_len     = found_len_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clear |=> (wr_ptr_reg == '0) && (valid_reg == '0))
        else $error("clear did not reset pointer and valid bits");

    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.push |=> valid_reg[$past(wr_ptr_reg)])
        else $error("pushed entry not marked valid");

    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.accept |=> !hit_reg)
        else $error("match flag not cleared on new request");

endmodule

// ===== hw/rtl/mrl_ctrl.sv =====
// Controller: request handshake, scan sequencing and response handshake.
`timescale 1ns / 1ps

module mrl_ctrl
    import mrl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic [CMD_W-1:0] req_cmd,
    output logic             req_ready,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output ctl_t             ctl,
    input  sts_t             sts
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   slot_free;

    assign accept    = req_valid && (state_reg == S_IDLE);
    assign slot_free = !out_valid_reg || rsp_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (req_cmd == CMD_LOOKUP) ? S_SCAN : S_EMIT;
                end
            end
            S_SCAN:
            begin
                if (sts.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready    = (state_reg == S_IDLE);
        ctl.accept   = accept;
        ctl.clear    = accept && (req_cmd == CMD_CLEAR);
        ctl.push     = accept && (req_cmd == CMD_PUSH);
        ctl.rd_en    = (state_reg == S_SCAN);
        ctl.load_out = (state_reg == S_EMIT) && slot_free;

        out_valid_next = out_valid_reg;
        if (ctl.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp_valid = out_valid_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req_cmd == CMD_LOOKUP)) |=> (state_reg == S_SCAN))
        else $error("lookup request did not start a scan");

    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SCAN) && sts.scan_last) |=> (state_reg == S_DRAIN))
        else $error("scan end did not drain the compare stage");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EMIT))
        else $error("response raised outside the emit state");

endmodule

// ===== verif/mrl_response_checker.sv =====
// Response checker for the message ring: predicts every response and compares it.
`timescale 1ns / 1ps

module mrl_response_checker
    import mrl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    mrl_req_if   req,
    mrl_rsp_if   rsp,
    output int   fail_count,
    output int   outstanding
);

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic              found;
        logic [TYPE_W-1:0] found_type;
        logic [LEN_W-1:0]  found_len;
    } lookup_rsp_t;

    logic [ID_W-1:0]   ring_id   [RING_DEPTH_DEF];
    logic [TYPE_W-1:0] ring_type [RING_DEPTH_DEF];
    logic [LEN_W-1:0]  ring_len  [RING_DEPTH_DEF];
    int                wr_ptr;
    lookup_rsp_t       awaited_rsps[$];
    int                n_fail = 0;
    int                n_awaited = 0;

    assign fail_count  = n_fail;
    assign outstanding = n_awaited;

    function automatic void wipe_ring();
        for (int i = 0; i < RING_DEPTH_DEF; i++)
        begin
            ring_id[i]   = '0;
            ring_type[i] = '0;
            ring_len[i]  = '0;
        end
        wr_ptr = 0;
    endfunction

    // Updates the ring copy for one request and returns the response it must give.
    function automatic lookup_rsp_t apply_request(input logic [CMD_W-1:0] cmd,
                                                  input logic [ID_W-1:0] id,
                                                  input logic [TYPE_W-1:0] typ,
                                                  input logic [LEN_W-1:0] len);
        lookup_rsp_t r;
        r = '0;
        case (cmd)
            CMD_CLEAR:
                wipe_ring();
            CMD_PUSH:
            begin
                ring_id[wr_ptr]   = id;
                ring_type[wr_ptr] = typ;
                ring_len[wr_ptr]  = len;
                wr_ptr = (wr_ptr + 1) % RING_DEPTH_DEF;
            end
            CMD_LOOKUP:
            begin
                // Ascending scan, so the last match (highest index) is what stays.
                for (int i = 0; i < RING_DEPTH_DEF; i++)
                begin
                    if (ring_id[i] == id)
                    begin
                        r.found      = 1'b1;
                        r.found_type = ring_type[i];
                        r.found_len  = ring_len[i];
                    end
                end
            end
            default:
                ;
        endcase
        return r;
    endfunction

    function automatic void note_failure(input string what, input lookup_rsp_t want,
                                         input lookup_rsp_t got);
        if (n_fail < MAX_REPORTS)
            $display("%0t: %s: expected found=%0d type=%0d len=%0d, got found=%0d type=%0d len=%0d",
                     $realtime, what, want.found, want.found_type, want.found_len,
                     got.found, got.found_type, got.found_len);
        n_fail++;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lookup_rsp_t want;
        lookup_rsp_t got;
        if (!rst_n)
        begin
            wipe_ring();
            awaited_rsps.delete();
        end
        else
        begin
            // Responses first: a request taken at this edge cannot be answered at it.
            if (rsp.valid && rsp.ready)
            begin
                got.found      = rsp.found;
                got.found_type = rsp.found_type;
                got.found_len  = rsp.found_len;
                if (awaited_rsps.size() == 0)
                    note_failure("response with no request waiting", '0, got);
                else
                begin
                    want = awaited_rsps.pop_front();
                    if (got.found !== want.found || got.found_type !== want.found_type ||
                        got.found_len !== want.found_len)
                        note_failure("response mismatch", want, got);
                end
            end
            if (req.valid && req.ready)
                awaited_rsps.push_back(apply_request(req.cmd, req.msg_id, req.msg_type,
                                                     req.msg_len));
        end
        n_awaited = awaited_rsps.size();
    end

endmodule

// ===== verif/message_ring_with_id_lookup_tb.sv =====
// Testbench top for the message ring: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module message_ring_with_id_lookup_tb
    import mrl_pkg::*;
;

    localparam int               RANDOM_REQUESTS = 1850;
    localparam int               IDLE_LIMIT      = 2000;
    localparam int               DRAIN_CYCLES    = 40;
    localparam logic [CMD_W-1:0] CMD_UNUSED      = 2'd3;
    localparam logic [ID_W-1:0]  ID_MAX          = '1;

    logic            clk;
    logic            rst_n;
    int              fail_count;
    int              outstanding;
    int              idle_cycles;
    bit              no_gaps;
    logic [ID_W-1:0] recent_ids [RING_DEPTH_DEF];
    int              recent_slot;

    mrl_req_if req_ch ();
    mrl_rsp_if rsp_ch ();

    message_ring_with_id_lookup u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    mrl_response_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                                input logic [TYPE_W-1:0] typ, input logic [LEN_W-1:0] len);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.cmd      <= cmd;
        req_ch.msg_id   <= id;
        req_ch.msg_type <= typ;
        req_ch.msg_len  <= len;
        req_ch.valid    <= 1'b1;
        if (cmd == CMD_PUSH)
        begin
            recent_ids[recent_slot] = id;
            recent_slot = (recent_slot + 1) % RING_DEPTH_DEF;
        end
        do
            @(posedge clk);
        while (!(req_ch.valid && req_ch.ready));
        @(negedge clk);
    endtask

    // Keys lean toward zero, the top id, a few small values and ids pushed lately,
    // so lookups hit often and duplicates are common.
    function automatic logic [ID_W-1:0] pick_id();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return ID_MAX;
            2, 3, 4: return ID_W'($urandom_range(1, 6));
            5, 6:    return recent_ids[$urandom_range(0, RING_DEPTH_DEF - 1)];
            default: return ID_W'($urandom);
        endcase
    endfunction

    initial
    begin
        int               roll;
        logic [CMD_W-1:0] cmd;
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.cmd      = CMD_CLEAR;
        req_ch.msg_id   = '0;
        req_ch.msg_type = '0;
        req_ch.msg_len  = '0;
        no_gaps         = 1'b0;
        recent_slot     = 0;
        foreach (recent_ids[i])
            recent_ids[i] = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Fresh ring: id zero matches every record, any other id misses.
        send_request(CMD_LOOKUP, '0, '0, '0);
        send_request(CMD_LOOKUP, ID_MAX, 8'hff, 16'hffff);
        send_request(CMD_PUSH, ID_MAX, 8'hff, 16'hffff);
        send_request(CMD_PUSH, 31'h5555_5555, 8'haa, 16'haaaa);
        send_request(CMD_PUSH, 31'h2aaa_aaaa, 8'h55, 16'h5555);
        send_request(CMD_PUSH, ID_MAX, 8'h01, 16'h0001);
        // Two records hold the top id; the higher index has to win.
        send_request(CMD_LOOKUP, ID_MAX, '0, '0);
        send_request(CMD_PUSH, '0, 8'h12, 16'h3456);
        // A pushed zero id loses to the cleared records above it.
        send_request(CMD_LOOKUP, '0, '0, '0);
        send_request(CMD_UNUSED, ID_MAX, 8'hff, 16'hffff);
        send_request(CMD_LOOKUP, 31'h5555_5555, 8'hff, 16'hffff);
        send_request(CMD_LOOKUP, 31'h2aaa_aaaa, '0, '0);
        send_request(CMD_CLEAR, ID_MAX, 8'hff, 16'hffff);
        send_request(CMD_LOOKUP, ID_MAX, '0, '0);
        send_request(CMD_LOOKUP, '0, '0, '0);
        send_request(CMD_PUSH, 31'd1, '0, '0);
        send_request(CMD_LOOKUP, 31'd1, '0, '0);

        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n % 150 == 0)
                no_gaps = ($urandom_range(0, 3) == 0);
            roll = $urandom_range(0, 99);
            if (roll < 2)
                cmd = CMD_CLEAR;
            else if (roll < 5)
                cmd = CMD_UNUSED;
            else if (roll < 52)
                cmd = CMD_PUSH;
            else
                cmd = CMD_LOOKUP;
            send_request(cmd, pick_id(), TYPE_W'($urandom), LEN_W'($urandom));
        end
        req_ch.valid <= 1'b0;

        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Response side: a random stall before each response is taken.
    initial
    begin
        int stall;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, 7);
            if (stall != 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(rsp_ch.valid && rsp_ch.ready));
            @(negedge clk);
        end
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/mrl_pkg.sv
hw/rtl/mrl_req_if.sv
hw/rtl/mrl_rsp_if.sv
hw/rtl/mrl_ram.sv
hw/rtl/mrl_dp.sv
hw/rtl/mrl_ctrl.sv
hw/rtl/message_ring_with_id_lookup.sv
verif/mrl_response_checker.sv
verif/message_ring_with_id_lookup_tb.sv
